// ===== rtl/mctc_pkg.sv =====
// Shared types and constants of the media clock time converter.
package mctc_pkg;

    // Request kinds carried on the func field.
    localparam logic [1:0] FUNC_CONVERT = 2'd0;
    localparam logic [1:0] FUNC_REVERT  = 2'd1;
    localparam logic [1:0] FUNC_SLAM    = 2'd2;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_RATE_NUM    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RATE_DEN    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TIME_OFFSET = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CONV_NUM    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CONV_DEN    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_WRAP_LIMIT  = 3'd5;

    // Register values after reset.
    localparam logic [31:0] RATE_NUM_RST    = 32'd0;
    localparam logic [31:0] RATE_DEN_RST    = 32'd1;
    localparam logic [63:0] TIME_OFFSET_RST = 64'd0;
    localparam logic [31:0] CONV_NUM_RST    = 32'd100000;
    localparam logic [31:0] CONV_DEN_RST    = 32'd9;
    localparam logic [32:0] WRAP_LIMIT_RST  = 33'h0_1FFF_FFFF;

    // Start of one scaling operation floor(x * num / den).
    typedef struct packed {
        logic        start;
        logic [63:0] x;
        logic [31:0] num;
        logic [31:0] den;
    } scale_req_t;

    // Completion of one scaling operation, saturated at all ones.
    typedef struct packed {
        logic        done;
        logic [63:0] quot;
    } scale_rsp_t;

endpackage

// ===== rtl/mctc_scale_unit.sv =====
// Shared multiply and radix-2 divide unit computing a saturated floor(x * num / den).
module mctc_scale_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  mctc_pkg::scale_req_t req,
    output mctc_pkg::scale_rsp_t rsp
);

    typedef enum logic [2:0] {
        SU_IDLE,
        SU_MUL_LO,
        SU_MUL_HI,
        SU_SUM,
        SU_CHECK,
        SU_DIV
    } su_state_t;

    su_state_t   state_reg;
    logic        done_reg;
    logic [63:0] x_reg;
    logic [31:0] num_reg;
    logic [31:0] den_reg;
    logic [63:0] prod_reg;
    logic [31:0] carry_reg;
    logic [31:0] low_reg;
    logic [31:0] rem_reg;
    logic [63:0] quo_reg;
    logic [5:0]  cnt_reg;

    logic [31:0] mul_a;
    logic [63:0] mul_p;
    logic [32:0] trial;
    logic [33:0] diff;
    logic        ge;
    logic        sat;

    // One 32x32 multiplier serves both halves of the 64-bit operand.
    assign mul_a = (state_reg == SU_MUL_LO) ? x_reg[31:0] : x_reg[63:32];
    assign mul_p = {32'd0, mul_a} * {32'd0, num_reg};

    // One restoring division step: the remainder gains the next dividend bit.
    assign trial = {rem_reg, quo_reg[63]};
    assign diff  = {1'b0, trial} - {2'b00, den_reg};
    assign ge    = ~diff[33];

    // The quotient needs more than 64 bits exactly when the top word of the
    // product is not below the divisor.
    assign sat = (prod_reg[63:32] >= den_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SU_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= (state_reg == SU_CHECK && sat)
                     || (state_reg == SU_DIV && cnt_reg == 6'd63);
            unique case (state_reg)
                SU_IDLE: begin
                    if (req.start) begin
                        x_reg     <= req.x;
                        num_reg   <= req.num;
                        den_reg   <= req.den;
                        state_reg <= SU_MUL_LO;
                    end
                end
                SU_MUL_LO: begin
                    prod_reg  <= mul_p;
                    state_reg <= SU_MUL_HI;
                end
                SU_MUL_HI: begin
                    low_reg   <= prod_reg[31:0];
                    carry_reg <= prod_reg[63:32];
                    prod_reg  <= mul_p;
                    state_reg <= SU_SUM;
                end
                SU_SUM: begin
                    // Upper 64 bits of the 96-bit product.
                    prod_reg  <= prod_reg + {32'd0, carry_reg};
                    state_reg <= SU_CHECK;
                end
                SU_CHECK: begin
                    if (sat) begin
                        quo_reg   <= '1;
                        state_reg <= SU_IDLE;
                    end else begin
                        rem_reg   <= prod_reg[63:32];
                        quo_reg   <= {prod_reg[31:0], low_reg};
                        cnt_reg   <= '0;
                        state_reg <= SU_DIV;
                    end
                end
                SU_DIV: begin
                    rem_reg <= ge ? diff[31:0] : trial[31:0];
                    quo_reg <= {quo_reg[62:0], ge};
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63) begin
                        state_reg <= SU_IDLE;
                    end
                end
                default: state_reg <= SU_IDLE;
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;

endmodule

// ===== rtl/media_clock_time_converter_unit.sv =====
// Top level of the media clock time converter: request sequencer, anchors and registers.
//
//  Channel   Direction  Handshake            Payload
//  s_        in         s_valid / s_ready    s_func, s_tick_value, s_time_value
//  m_        out        m_valid / m_ready    m_result_value, m_div_error
//  cfg_wr_   in         cfg_wr_en only       cfg_wr_index, cfg_wr_data
//
// A convert or revert request puts its result out after two chained scalings on one
// shared unit, each a 32x32 multiply of both operand halves and 64 radix-2 division
// steps; a scaling that saturates skips the division. Slam, unused codes and zero
// divisors skip the scaling unit and go from the preparation step to the output. The
// input is ready again as soon as a result is loaded. Reset (aresetn, synchronous,
// active low) clears the anchors, loads the register defaults and empties the output
// register. A stalled m_ready holds the result; a new request may be taken while the
// previous result waits.
module media_clock_time_converter_unit (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [32:0] s_tick_value,
    input  logic [63:0] s_time_value,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_result_value,
    output logic        m_div_error,

    input  logic                             cfg_wr_en,
    input  logic [mctc_pkg::CFG_INDEX_W-1:0] cfg_wr_index,
    input  logic [63:0]                      cfg_wr_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SC1,
        ST_SC2,
        ST_ADD_ANCHOR,
        ST_ADD_OFFSET,
        ST_FINISH,
        ST_OUT
    } state_t;

    // Configuration registers.
    logic [31:0] rate_num_reg;
    logic [31:0] rate_den_reg;
    logic [63:0] time_offset_reg;
    logic [31:0] conv_num_reg;
    logic [31:0] conv_den_reg;
    logic [32:0] wrap_limit_reg;

    // Sequencer, anchors and captured request.
    state_t      state_reg;
    logic [32:0] anchor_tick_reg;
    logic [63:0] anchor_time_reg;
    logic [1:0]  func_reg;
    logic [32:0] tick_reg;
    logic [63:0] time_reg;
    logic [63:0] acc_reg;
    logic        err_reg;

    // Request register toward the scaling unit.
    logic        sc_start_reg;
    logic [63:0] sc_x_reg;
    logic [31:0] sc_num_reg;
    logic [31:0] sc_den_reg;

    // Output register.
    logic        m_valid_reg;
    logic [63:0] m_result_value_reg;
    logic        m_div_error_reg;

    mctc_pkg::scale_req_t sc_req;
    mctc_pkg::scale_rsp_t sc_rsp;

    logic        is_convert;
    logic        prep_scale;
    logic [63:0] elapsed_ticks;
    logic        out_free;

    assign is_convert = (func_reg == mctc_pkg::FUNC_CONVERT);
    assign out_free   = !m_valid_reg || m_ready;

    // A convert or revert whose divisors are all nonzero goes on to the scaling unit.
    assign prep_scale = (is_convert && conv_den_reg != '0 && rate_den_reg != '0)
                     || (func_reg == mctc_pkg::FUNC_REVERT && conv_num_reg != '0
                         && rate_num_reg != '0);

    // Ticks since the anchor; a count below the anchor is taken to have wrapped at
    // the wrap limit, and the sum is kept modulo 2^64.
    always_comb begin
        if (tick_reg < anchor_tick_reg) begin
            elapsed_ticks = {31'd0, wrap_limit_reg} - {31'd0, anchor_tick_reg}
                          + {31'd0, tick_reg};
        end else begin
            elapsed_ticks = {31'd0, tick_reg - anchor_tick_reg};
        end
    end

    always_comb begin
        sc_req.start = sc_start_reg;
        sc_req.x     = sc_x_reg;
        sc_req.num   = sc_num_reg;
        sc_req.den   = sc_den_reg;
    end

    mctc_scale_unit u_scale (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (sc_req),
        .rsp     (sc_rsp)
    );

    // Configuration writes must arrive only while the block is idle; the block itself does not enforce this.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_num_reg    <= mctc_pkg::RATE_NUM_RST;
            rate_den_reg    <= mctc_pkg::RATE_DEN_RST;
            time_offset_reg <= mctc_pkg::TIME_OFFSET_RST;
            conv_num_reg    <= mctc_pkg::CONV_NUM_RST;
            conv_den_reg    <= mctc_pkg::CONV_DEN_RST;
            wrap_limit_reg  <= mctc_pkg::WRAP_LIMIT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                mctc_pkg::REG_RATE_NUM:    rate_num_reg    <= cfg_wr_data[31:0];
                mctc_pkg::REG_RATE_DEN:    rate_den_reg    <= cfg_wr_data[31:0];
                mctc_pkg::REG_TIME_OFFSET: time_offset_reg <= cfg_wr_data;
                mctc_pkg::REG_CONV_NUM:    conv_num_reg    <= cfg_wr_data[31:0];
                mctc_pkg::REG_CONV_DEN:    conv_den_reg    <= cfg_wr_data[31:0];
                mctc_pkg::REG_WRAP_LIMIT:  wrap_limit_reg  <= cfg_wr_data[32:0];
                default: ;
            endcase
        end
    end

    // Request sequencer. Convert runs ticks through conv_num/conv_den and then
    // rate_num/rate_den; revert runs the inverse ratios. The output register is
    // loaded in ST_OUT once it is free, so the next request can be accepted while a
    // result is still waiting downstream.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            anchor_tick_reg <= '0;
            anchor_time_reg <= '0;
            sc_start_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            // The scaling unit is started on leaving the preparation step and again
            // when the first scaling completes.
            sc_start_reg <= (state_reg == ST_PREP && prep_scale)
                         || (state_reg == ST_SC1 && sc_rsp.done);
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        func_reg  <= s_func;
                        tick_reg  <= s_tick_value;
                        time_reg  <= s_time_value;
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    acc_reg <= '0;
                    err_reg <= !prep_scale
                            && (is_convert || func_reg == mctc_pkg::FUNC_REVERT);
                    unique case (func_reg)
                        mctc_pkg::FUNC_CONVERT: begin
                            if (conv_den_reg == '0 || rate_den_reg == '0) begin
                                state_reg <= ST_OUT;
                            end else begin
                                sc_x_reg     <= elapsed_ticks;
                                sc_num_reg   <= conv_num_reg;
                                sc_den_reg   <= conv_den_reg;
                                state_reg    <= ST_SC1;
                            end
                        end
                        mctc_pkg::FUNC_REVERT: begin
                            if (conv_num_reg == '0 || rate_num_reg == '0) begin
                                state_reg <= ST_OUT;
                            end else begin
                                sc_x_reg     <= time_reg - anchor_time_reg;
                                sc_num_reg   <= conv_den_reg;
                                sc_den_reg   <= conv_num_reg;
                                state_reg    <= ST_SC1;
                            end
                        end
                        mctc_pkg::FUNC_SLAM: begin
                            anchor_tick_reg <= tick_reg;
                            anchor_time_reg <= time_reg;
                            state_reg       <= ST_OUT;
                        end
                        default: state_reg <= ST_OUT;
                    endcase
                end
                ST_SC1: begin
                    if (sc_rsp.done) begin
                        sc_x_reg     <= sc_rsp.quot;
                        sc_num_reg   <= is_convert ? rate_num_reg : rate_den_reg;
                        sc_den_reg   <= is_convert ? rate_den_reg : rate_num_reg;
                        state_reg    <= ST_SC2;
                    end
                end
                ST_SC2: begin
                    if (sc_rsp.done) begin
                        acc_reg   <= sc_rsp.quot;
                        state_reg <= ST_ADD_ANCHOR;
                    end
                end
                ST_ADD_ANCHOR: begin
                    acc_reg   <= acc_reg + (is_convert ? anchor_time_reg
                                                       : {31'd0, anchor_tick_reg});
                    state_reg <= ST_ADD_OFFSET;
                end
                ST_ADD_OFFSET: begin
                    acc_reg   <= acc_reg + time_offset_reg;
                    state_reg <= ST_FINISH;
                end
                ST_FINISH: begin
                    // A convert never moves the time anchor backward.
                    if (is_convert) begin
                        anchor_tick_reg <= tick_reg;
                        if (acc_reg > anchor_time_reg) begin
                            anchor_time_reg <= acc_reg;
                        end else begin
                            acc_reg <= anchor_time_reg;
                        end
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_result_value_reg <= acc_reg;
                        m_div_error_reg    <= err_reg;
                        state_reg          <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_result_value = m_result_value_reg;
    assign m_div_error    = m_div_error_reg;

    // The scaling unit only reports completion while the sequencer waits for it.
    a_scale_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        sc_rsp.done |-> (state_reg == ST_SC1 || state_reg == ST_SC2))
        else $error("scaling unit finished outside a scaling step");

    // A zero-divisor result always carries a zero value.
    a_error_zero_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_div_error) |-> (m_result_value == 64'd0))
        else $error("division error reported with a nonzero result");

    // The anchors move only on a slam or at the end of a convert.
    a_anchor_update: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && (!$stable(anchor_tick_reg) || !$stable(anchor_time_reg)))
        |-> ($past(state_reg) == ST_PREP || $past(state_reg) == ST_FINISH))
        else $error("anchor changed outside slam or convert completion");

    // A result still waiting in the output register is never overwritten by the result
    // of the request after it.
    a_out_not_lost: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && m_valid && !m_ready) |=> $stable(m_result_value))
        else $error("pending result overwritten");

endmodule
